>>> hw/rtl/drf_pkg.sv
// shared types and constants for the route finder
package drf_pkg;

    localparam logic [1:0] REQ_LINK  = 2'd0;
    localparam logic [1:0] REQ_NODE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  from_node;
        logic [3:0]  to_node;
        logic        link_present;
        logic        link_working;
        logic [23:0] link_cost;
        logic        node_working;
    } t_req;

    typedef struct packed {
        logic [3:0] path_node;
        logic [3:0] hop_index;
        logic       route_found;
        logic       last;
    } t_res;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic write_link;
        logic write_node;
        logic init;
        logic scan;
        logic settle;
        logic relax;
        logic walk;
        logic walk_step;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic any;
        logic best_is_dst;
        logic relax_done;
        logic out_link;
        logic walk_done;
        logic bad_query;
    } t_sts;

endpackage

>>> hw/rtl/drf_datapath.sv
// tables, distance registers, min scan, relax pass and route walk
module drf_datapath import drf_pkg::*; #(
    parameter int NODES     = 16,
    parameter int COST_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_req         i_req,
    input  logic [4:0]   i_nodes_in_use,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    output logic [3:0]   o_path_node,
    output logic [3:0]   o_hop_index,
    output logic         o_walk_last
);
    localparam int NB        = (NODES > 2) ? $clog2(NODES) : 1;
    localparam int DIST_BITS = COST_BITS + 6;
    localparam int CNT_BITS  = NB + 1;
    localparam int AB        = 2 * NB;
    localparam int CLR_BITS  = AB + 1;
    localparam logic [DIST_BITS-1:0] DIST_INF = '1;

    logic [1:0]           r_flags [NODES*NODES];
    logic [COST_BITS-1:0] r_cost  [NODES*NODES];
    logic [NODES-1:0]     r_up;
    logic [DIST_BITS-1:0] r_dist  [NODES];
    logic [NB-1:0]        r_pred  [NODES];
    logic [NODES-1:0]     r_settled;

    logic [CLR_BITS-1:0]  r_clr;
    logic [CNT_BITS-1:0]  r_n;
    logic [NB-1:0]        r_src, r_dst;
    logic [CNT_BITS-1:0]  r_i;
    logic [NB-1:0]        r_k;
    logic                 r_any;
    logic [DIST_BITS-1:0] r_best;
    logic                 r_out_link;
    logic [NB-1:0]        r_node;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [NB-1:0]        r_path  [NODES];
    logic [1:0]           r_rd_flags;
    logic [COST_BITS-1:0] r_rd_cost;
    logic                 r_rd_vld;
    logic [NB-1:0]        r_rd_i;
    logic [CNT_BITS-1:0]  r_hop;
    logic                 r_bad;

    logic [CNT_BITS-1:0]  w_n;
    logic [NB-1:0]        w_i;
    logic [AB-1:0]        w_waddr, w_raddr;
    logic [DIST_BITS:0]   w_sum;
    logic [DIST_BITS-1:0] w_sat;
    logic                 w_use;
    logic                 w_in_range;
    logic                 w_flag_we;
    logic [AB-1:0]        w_flag_addr;
    logic [1:0]           w_flag_data;
    logic [CNT_BITS-1:0]  w_pidx;

    always_comb begin
        if (i_nodes_in_use < 5'd2) w_n = CNT_BITS'(2);
        else if (32'(i_nodes_in_use) > NODES) w_n = CNT_BITS'(NODES);
        else w_n = CNT_BITS'(i_nodes_in_use);
    end

    assign w_in_range = (32'(i_req.from_node) < NODES) && (32'(i_req.to_node) < NODES);
    assign w_waddr = AB'(32'(i_req.from_node) * NODES + 32'(i_req.to_node));
    assign w_i     = r_i[NB-1:0];
    assign w_raddr = AB'(32'(r_k) * NODES + 32'(w_i));

    // clearing pass after reset shares the flag write port
    assign w_flag_we   = i_cmd.clear || (i_cmd.write_link && w_in_range);
    assign w_flag_addr = i_cmd.clear ? r_clr[AB-1:0] : w_waddr;
    assign w_flag_data = i_cmd.clear ? 2'b00 : {i_req.link_working, i_req.link_present};

    // table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_link && w_in_range) r_cost[w_waddr] <= i_req.link_cost[COST_BITS-1:0];
        r_rd_cost <= r_cost[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_flag_we) r_flags[w_flag_addr] <= w_flag_data;
        r_rd_flags <= r_flags[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_up  <= '1;
        end else begin
            if (i_cmd.clear) r_clr <= r_clr + 1'b1;
            if (i_cmd.write_node && 32'(i_req.from_node) < NODES)
                r_up[NB'(i_req.from_node)] <= i_req.node_working;
        end
    end

    assign w_use = (r_rd_flags == 2'b11) && r_up[r_k] && r_up[r_rd_i];
    assign w_sum = {1'b0, r_dist[r_k]} + (DIST_BITS+1)'(r_rd_cost);
    assign w_sat = (w_sum >= {1'b0, DIST_INF}) ? DIST_INF - 1'b1 : w_sum[DIST_BITS-1:0];

    always_ff @(posedge i_clk) begin
        r_rd_vld <= i_cmd.relax && (r_i < r_n);
        if (i_cmd.init) begin
            r_n   <= w_n;
            r_src <= NB'(i_req.from_node);
            r_dst <= NB'(i_req.to_node);
            r_bad <= (32'(i_req.from_node) >= 32'(w_n)) || (32'(i_req.to_node) >= 32'(w_n))
                     || (i_req.from_node == i_req.to_node);
            for (int j = 0; j < NODES; j++) begin
                r_dist[j] <= (32'(i_req.from_node) == j) ? '0 : DIST_INF;
                r_pred[j] <= '0;
            end
            r_settled <= '0;
            r_i <= '0; r_any <= 1'b0; r_best <= DIST_INF; r_k <= '0;
        end
        if (i_cmd.scan && r_i < r_n) begin
            if (!r_settled[w_i] && r_dist[w_i] < r_best) begin
                r_best <= r_dist[w_i];
                r_k    <= w_i;
                r_any  <= 1'b1;
            end
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.settle) begin
            r_settled[r_k] <= 1'b1;
            r_i <= '0;
            r_out_link <= 1'b0;
        end
        if (i_cmd.relax) begin
            if (r_i < r_n) begin
                r_rd_i   <= w_i;
                r_i      <= r_i + 1'b1;
            end else if (!r_rd_vld) begin
                // pass finished, rearm the min scan
                r_i    <= '0;
                r_any  <= 1'b0;
                r_best <= DIST_INF;
            end
            if (r_rd_vld && w_use) begin
                r_out_link <= 1'b1;
                if (!r_settled[r_rd_i] && w_sat < r_dist[r_rd_i]) begin
                    r_dist[r_rd_i] <= w_sat;
                    r_pred[r_rd_i] <= r_k;
                end
            end
        end
        if (i_cmd.walk) begin
            r_node  <= r_dst;
            r_path[0] <= r_dst;
            r_cnt   <= CNT_BITS'(1);
            r_hop   <= '0;
        end
        if (i_cmd.walk_step) begin
            if (r_node != r_src && r_cnt < r_n) begin
                r_node <= r_pred[r_node];
                r_path[r_cnt[NB-1:0]] <= r_pred[r_node];
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_hop <= r_hop + 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.clear_done  = (32'(r_clr) >= NODES * NODES);
        o_sts.scan_done   = (r_i >= r_n);
        o_sts.any         = r_any;
        o_sts.best_is_dst = (r_k == r_dst);
        o_sts.relax_done  = (r_i >= r_n) && !r_rd_vld;
        o_sts.out_link    = r_out_link;
        o_sts.walk_done   = !(r_node != r_src && r_cnt < r_n);
        o_sts.bad_query   = r_bad;
    end

    assign w_pidx      = r_cnt - 1'b1 - r_hop;
    assign o_path_node = 4'(r_path[w_pidx[NB-1:0]]);
    assign o_hop_index = 4'(r_hop);
    assign o_walk_last = (r_hop + 1'b1 == r_cnt);
endmodule

>>> hw/rtl/drf_ctrl.sv
// request sequencer for writes, search and route output
module drf_ctrl import drf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_req i_req,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    input  logic i_out_free,
    output logic o_emit,
    output logic o_emit_fail,
    input  logic i_walk_last
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_RELAX = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_CHECK_FAIL = 3'd6;
    localparam logic [2:0] S_CLEAR = 3'd7;

    logic [2:0] r_state, n_state;
    logic       w_take;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_emit      = 1'b0;
        o_emit_fail = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (!i_sts.clear_done) o_cmd.clear = 1'b1;
                else n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_take) begin
                    case (i_req.req_type)
                        REQ_LINK:  o_cmd.write_link = 1'b1;
                        REQ_NODE:  o_cmd.write_node = 1'b1;
                        REQ_QUERY: begin
                            o_cmd.init = 1'b1;
                            n_state = S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                if (i_sts.bad_query) begin
                    if (i_out_free) begin
                        o_emit_fail = 1'b1;
                        n_state = S_IDLE;
                    end
                end else n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!i_sts.scan_done) o_cmd.scan = 1'b1;
                else if (!i_sts.any || !i_sts.best_is_dst) begin
                    if (!i_sts.any) begin
                        if (i_out_free) begin
                            o_emit_fail = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        o_cmd.settle = 1'b1;
                        n_state = S_RELAX;
                    end
                end else begin
                    o_cmd.walk = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_RELAX: begin
                o_cmd.relax = 1'b1;
                if (i_sts.relax_done) begin
                    if (i_sts.out_link) n_state = S_SCAN;
                    else n_state = S_CHECK_FAIL;
                end
            end
            S_WALK: begin
                if (!i_sts.walk_done) o_cmd.walk_step = 1'b1;
                else n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    o_cmd.walk_step = 1'b1;
                    if (i_walk_last) n_state = S_IDLE;
                end
            end
            S_CHECK_FAIL: begin
                if (i_out_free) begin
                    o_emit_fail = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end
endmodule

>>> hw/rtl/dijkstra_route_finder_top.sv
// throughput: one transaction at a time; the min scan and the relax pass over the link memory
// each visit one node per cycle, and the output register stalls the controller while full
// reset: synchronous active low; all nodes working, nodes_in_use = 16, then a clearing pass over
// all NODES*NODES link entries empties the link table while o_in_ready stays low
module dijkstra_route_finder_top import drf_pkg::*; #(
    parameter int NODES     = 16,
    parameter int COST_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_req       i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_res       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_data
);
    logic [4:0] r_nodes_in_use;
    t_cmd       w_cmd;
    t_sts       w_sts;
    logic       w_emit, w_emit_fail, w_walk_last, w_out_free;
    logic [3:0] w_path_node, w_hop_index;
    t_res       r_out;
    logic       r_out_valid;

    // config register, writable any cycle
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_nodes_in_use <= 5'd16;
        else if (i_cfg_valid) r_nodes_in_use <= i_cfg_data;
    end

    // output slot is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    drf_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_req(i_in_data), .o_in_ready,
        .i_sts(w_sts), .o_cmd(w_cmd),
        .i_out_free(w_out_free), .o_emit(w_emit), .o_emit_fail(w_emit_fail),
        .i_walk_last(w_walk_last)
    );

    drf_datapath #(.NODES(NODES), .COST_BITS(COST_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_req(i_in_data), .i_nodes_in_use(r_nodes_in_use),
        .i_cmd(w_cmd), .o_sts(w_sts),
        .o_path_node(w_path_node), .o_hop_index(w_hop_index), .o_walk_last(w_walk_last)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_emit || w_emit_fail) r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
        if (w_emit) r_out <= '{w_path_node, w_hop_index, 1'b1, w_walk_last};
        else if (w_emit_fail) r_out <= '{4'd0, 4'd0, 1'b0, 1'b1};
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // a new result only replaces a taken one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_data)) else $error("result overwritten");
    // a failed route always closes the transaction
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.route_found) |-> o_out_data.last) else $error("fail not last");
    // no input taken while results are pending from the controller
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit || w_emit_fail) |-> !o_in_ready) else $error("emit while idle");
`endif
endmodule
